### rtl/core/cpfa_pkg.sv
`timescale 1ns / 1ps

package cpfa_pkg;

    typedef enum logic [2:0] {
        PS_FREE   = 3'd0,
        PS_SINGLE = 3'd1,
        PS_HEAD   = 3'd2,
        PS_TAIL   = 3'd3,
        PS_PART   = 3'd4
    } t_page_state;

    typedef enum logic [2:0] {
        RS_OK           = 3'd0,
        RS_NO_ROOM      = 3'd1,
        RS_BAD_COUNT    = 3'd2,
        RS_OUT_OF_BOUND = 3'd3,
        RS_MISALIGNED   = 3'd4,
        RS_DOUBLE_FREE  = 3'd5,
        RS_NOT_HEAD     = 3'd6,
        RS_BROKEN       = 3'd7
    } t_status;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic CFG_REGION_BASE = 1'b0;
    localparam logic CFG_PAGE_COUNT  = 1'b1;

    localparam int CFG_DATA_W   = 32;
    localparam int PAGE_COUNT_W = 13;

    localparam logic [31:0]             REGION_BASE_RST = 32'd1048576;
    localparam logic [PAGE_COUNT_W-1:0] PAGE_COUNT_RST  = 13'd4096;

    typedef struct packed {
        logic        opcode;
        logic [12:0] request_pages;
        logic [31:0] frame_address;
    } t_cmd_word;

    typedef struct packed {
        logic [31:0] result_address;
        logic [2:0]  status;
    } t_res_word;

endpackage

### rtl/core/cpfa_map_ram.sv
`timescale 1ns / 1ps

module cpfa_map_ram
    import cpfa_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_rd_addr,
    output logic [2:0]    o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [2:0]    i_wr_data
);

    logic [2:0] r_mem [DEPTH];
    logic [2:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/cpfa_seq.sv
`timescale 1ns / 1ps

module cpfa_seq
    import cpfa_pkg::*;
#(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_BYTES = 4096,
    parameter int IW         = $clog2(MAX_PAGES),
    parameter int CW         = $clog2(MAX_PAGES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [31:0]   i_base,
    input  logic [CW-1:0] i_live,
    input  logic          i_start,
    input  t_cmd_word     i_cmd,
    output logic          o_busy,
    output logic          o_res_valid,
    output t_res_word     o_res,
    output logic [IW-1:0] o_rd_addr,
    input  logic [2:0]    i_rd_data,
    output logic          o_wr_en,
    output logic [IW-1:0] o_wr_addr,
    output logic [2:0]    o_wr_data
);

    localparam int SH = $clog2(PAGE_BYTES);

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_SCAN = 6'b000100,
        S_MARK = 6'b001000,
        S_FCHK = 6'b010000,
        S_WALK = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_chk, n_chk;
    logic [CW-1:0] r_run, n_run;
    logic [CW-1:0] r_want, n_want;
    logic [IW-1:0] r_start, n_start;
    logic [CW-1:0] r_end, n_end;
    logic          r_res_valid, n_res_valid;
    t_res_word     r_res, n_res;

    logic          wr_en;
    t_page_state   wr_data;
    t_page_state   rd_state;
    logic [31:0]   offs;
    logic [31:0]   pg;
    logic          oob;
    logic          mis;
    logic [CW-1:0] run_inc;
    logic [CW-1:0] start_c;
    logic [31:0]   alloc_addr;

    assign rd_state   = t_page_state'(i_rd_data);
    assign offs       = i_cmd.frame_address - i_base;
    assign pg         = offs >> SH;
    assign oob        = (i_cmd.frame_address < i_base) || (pg >= 32'(i_live));
    assign mis        = i_cmd.frame_address[SH-1:0] != '0;
    assign run_inc    = (rd_state == PS_FREE) ? (r_run + CW'(1)) : '0;
    assign start_c    = r_chk + CW'(1) - r_want;
    assign alloc_addr = i_base + (32'(r_start) << SH);

    always_comb begin
        n_state     = r_state;
        n_chk       = r_chk;
        n_run       = r_run;
        n_want      = r_want;
        n_start     = r_start;
        n_end       = r_end;
        n_res_valid = 1'b0;
        n_res       = r_res;
        wr_en       = 1'b0;
        wr_data     = PS_FREE;
        case (r_state)
            S_CLR: begin
                wr_en = 1'b1;
                if (r_chk == CW'(MAX_PAGES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_chk = r_chk + CW'(1);
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_res.result_address = '0;
                    if (i_cmd.opcode == OP_ALLOC) begin
                        if (i_cmd.request_pages == '0) begin
                            n_res_valid  = 1'b1;
                            n_res.status = RS_BAD_COUNT;
                        end else if (32'(i_cmd.request_pages) > 32'(i_live)) begin
                            n_res_valid  = 1'b1;
                            n_res.status = RS_NO_ROOM;
                        end else begin
                            n_want  = CW'(i_cmd.request_pages);
                            n_run   = '0;
                            n_chk   = '0;
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (oob) begin
                            n_res_valid  = 1'b1;
                            n_res.status = RS_OUT_OF_BOUND;
                        end else if (mis) begin
                            n_res_valid  = 1'b1;
                            n_res.status = RS_MISALIGNED;
                        end else begin
                            n_chk   = CW'(pg);
                            n_state = S_FCHK;
                        end
                    end
                end
            end
            S_SCAN: begin
                n_run = run_inc;
                if (run_inc == r_want) begin
                    n_start = IW'(start_c);
                    n_end   = r_chk;
                    n_chk   = start_c;
                    n_state = S_MARK;
                end else if ((r_chk + CW'(1)) == i_live) begin
                    n_res_valid          = 1'b1;
                    n_res.status         = RS_NO_ROOM;
                    n_res.result_address = '0;
                    n_state              = S_IDLE;
                end else begin
                    n_chk = r_chk + CW'(1);
                end
            end
            S_MARK: begin
                wr_en = 1'b1;
                if (r_want == CW'(1)) begin
                    wr_data = PS_SINGLE;
                end else if (IW'(r_chk) == r_start) begin
                    wr_data = PS_HEAD;
                end else if (r_chk == r_end) begin
                    wr_data = PS_TAIL;
                end else begin
                    wr_data = PS_PART;
                end
                if (r_chk == r_end) begin
                    n_res_valid          = 1'b1;
                    n_res.status         = RS_OK;
                    n_res.result_address = alloc_addr;
                    n_state              = S_IDLE;
                end else begin
                    n_chk = r_chk + CW'(1);
                end
            end
            S_FCHK: begin
                n_res.result_address = '0;
                case (rd_state)
                    PS_FREE: begin
                        n_res_valid  = 1'b1;
                        n_res.status = RS_DOUBLE_FREE;
                        n_state      = S_IDLE;
                    end
                    PS_SINGLE: begin
                        wr_en        = 1'b1;
                        n_res_valid  = 1'b1;
                        n_res.status = RS_OK;
                        n_state      = S_IDLE;
                    end
                    PS_HEAD: begin
                        wr_en   = 1'b1;
                        n_chk   = r_chk + CW'(1);
                        n_state = S_WALK;
                    end
                    default: begin
                        n_res_valid  = 1'b1;
                        n_res.status = RS_NOT_HEAD;
                        n_state      = S_IDLE;
                    end
                endcase
            end
            S_WALK: begin
                n_res.result_address = '0;
                if (r_chk >= i_live) begin
                    n_res_valid  = 1'b1;
                    n_res.status = RS_BROKEN;
                    n_state      = S_IDLE;
                end else begin
                    case (rd_state)
                        PS_TAIL: begin
                            wr_en        = 1'b1;
                            n_res_valid  = 1'b1;
                            n_res.status = RS_OK;
                            n_state      = S_IDLE;
                        end
                        PS_HEAD, PS_PART: begin
                            wr_en = 1'b1;
                            n_chk = r_chk + CW'(1);
                        end
                        default: begin
                            n_res_valid  = 1'b1;
                            n_res.status = RS_BROKEN;
                            n_state      = S_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_chk       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chk       <= n_chk;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run   <= n_run;
        r_want  <= n_want;
        r_start <= n_start;
        r_end   <= n_end;
        r_res   <= n_res;
    end

    assign o_busy      = r_state != S_IDLE;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign o_rd_addr   = n_chk[IW-1:0];
    assign o_wr_en     = wr_en;
    assign o_wr_addr   = r_chk[IW-1:0];
    assign o_wr_data   = wr_data;

    a_err_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && (r_res.status != RS_OK) |-> r_res.result_address == '0)
        else $error("failed result carries an address");

    a_mark_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK) |-> (IW'(r_chk) >= r_start) && (r_chk <= r_end))
        else $error("mark pointer outside the found run");

    a_walk_in_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en && (r_state == S_WALK) |-> r_chk < i_live)
        else $error("block release beyond live pages");

    a_scan_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> r_run < r_want)
        else $error("scan run passed request without stopping");

    a_no_res_in_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |=> !r_res_valid)
        else $error("result raised during clearing pass");

endmodule

### rtl/core/contiguous_page_frame_allocator_core.sv
`timescale 1ns / 1ps
// First-fit page frame allocator for one region of physical frames.
// Command channel: a word on i_cmd is taken on a clock edge with start high
// and busy low. Opcode allocate asks for request_pages contiguous pages,
// opcode free releases the page or block at frame_address.
// Result channel: one word per command on o_res for a single cycle, marked
// by o_res_valid; it must be taken then, as nothing holds it.
// Config port: i_cfg_we writes i_cfg_data to the register at i_cfg_idx
// (0 region base, 1 page count). The user must write only while busy is
// low; the block itself does not enforce it.
// The map (one read, one write port) is walked one entry a cycle: allocate
// scans from index 0 for the first free run, marks it or reports no room;
// free checks the addressed page and frees a block up to its tail. Bad
// count, no room by size or bad address are answered straight from idle.
// Commands are handled one at a time; busy stays high until the result.
// Reset: the map is cleared to free one entry a cycle, with busy high.
// PAGE_BYTES must be a power of two.

module contiguous_page_frame_allocator_core
    import cpfa_pkg::*;
#(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_cmd_word             i_cmd,
    output logic                  o_res_valid,
    output t_res_word             o_res,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(MAX_PAGES);
    localparam int CW = $clog2(MAX_PAGES + 1);

    logic [31:0]             r_region_base;
    logic [PAGE_COUNT_W-1:0] r_page_count;
    logic [CW-1:0]           live;

    logic [IW-1:0] rd_addr;
    logic [2:0]    rd_data;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [2:0]    wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_base <= REGION_BASE_RST;
            r_page_count  <= PAGE_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REGION_BASE: r_region_base <= i_cfg_data;
                CFG_PAGE_COUNT:  r_page_count  <= i_cfg_data[PAGE_COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign live = (32'(r_page_count) > 32'(MAX_PAGES)) ? CW'(MAX_PAGES)
                                                       : CW'(r_page_count);

    cpfa_seq #(
        .MAX_PAGES (MAX_PAGES),
        .PAGE_BYTES(PAGE_BYTES),
        .IW        (IW),
        .CW        (CW)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_base     (r_region_base),
        .i_live     (live),
        .i_start    (start),
        .i_cmd      (i_cmd),
        .o_busy     (busy),
        .o_res_valid(o_res_valid),
        .o_res      (o_res),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data)
    );

    cpfa_map_ram #(
        .DEPTH(MAX_PAGES),
        .AW   (IW)
    ) u_map (
        .i_clk    (i_clk),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data)
    );

endmodule

### dv/contiguous_page_frame_allocator_core_tb.sv
`timescale 1ns / 1ps

module contiguous_page_frame_allocator_core_tb
    import cpfa_pkg::*;
;

    localparam int unsigned MAX_PG   = 4096;
    localparam int unsigned PAGE_B   = 4096;
    localparam int unsigned IDLE_LIM = 40000;

    class frame_map_scoreboard;
        t_page_state page_map [MAX_PG];
        logic [31:0] region_base;
        logic [12:0] page_count;
        t_res_word   due_results [$];
        int          mismatches;
        int          n_alloc;
        int          n_free;
        int          status_seen [8];

        function new();
            foreach (page_map[i]) page_map[i] = PS_FREE;
            region_base = REGION_BASE_RST;
            page_count  = PAGE_COUNT_RST;
            mismatches  = 0;
            n_alloc     = 0;
            n_free      = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int unsigned live_pages();
            return (page_count > MAX_PG) ? MAX_PG : int'(page_count);
        endfunction

        function void set_cfg(logic idx, logic [31:0] data);
            if (idx == CFG_REGION_BASE) begin
                region_base = data;
            end else begin
                page_count = data[PAGE_COUNT_W-1:0];
            end
        endfunction

        // first-fit search; a single page is marked single, a run head/part/tail
        function t_status grab_run(int unsigned want, output logic [31:0] addr);
            int unsigned n;
            int unsigned run;
            int unsigned lead;
            addr = '0;
            n    = live_pages();
            run  = 0;
            if (want == 0) return RS_BAD_COUNT;
            if (want > n) return RS_NO_ROOM;
            for (int unsigned i = 0; i < n; i++) begin
                run = (page_map[i] == PS_FREE) ? run + 1 : 0;
                if (run == want) begin
                    lead = i + 1 - want;
                    if (want == 1) begin
                        page_map[lead] = PS_SINGLE;
                    end else begin
                        for (int unsigned k = lead; k <= i; k++) page_map[k] = PS_PART;
                        page_map[lead] = PS_HEAD;
                        page_map[i]    = PS_TAIL;
                    end
                    addr = region_base + 32'(lead * PAGE_B);
                    return RS_OK;
                end
            end
            return RS_NO_ROOM;
        endfunction

        function t_status release_frame(logic [31:0] frame);
            int unsigned       n;
            int unsigned       idx;
            longint unsigned   top;
            n   = live_pages();
            top = longint'({32'd0, region_base}) + longint'(n) * longint'(PAGE_B);
            if (frame < region_base || longint'({32'd0, frame}) >= top) return RS_OUT_OF_BOUND;
            if ((frame % PAGE_B) != 0) return RS_MISALIGNED;
            idx = (frame - region_base) / PAGE_B;
            if (page_map[idx] == PS_FREE) return RS_DOUBLE_FREE;
            if (page_map[idx] == PS_SINGLE) begin
                page_map[idx] = PS_FREE;
                return RS_OK;
            end
            if (page_map[idx] != PS_HEAD) return RS_NOT_HEAD;
            // walk stops at the page count; pages already walked stay free
            while (idx < n) begin
                if (page_map[idx] == PS_TAIL) begin
                    page_map[idx] = PS_FREE;
                    return RS_OK;
                end
                if (page_map[idx] != PS_HEAD && page_map[idx] != PS_PART) return RS_BROKEN;
                page_map[idx] = PS_FREE;
                idx++;
            end
            return RS_BROKEN;
        endfunction

        function t_res_word note_cmd(t_cmd_word w);
            t_res_word   r;
            logic [31:0] addr;
            addr = '0;
            if (w.opcode == OP_ALLOC) begin
                r.status = grab_run(w.request_pages, addr);
                n_alloc++;
            end else begin
                r.status = release_frame(w.frame_address);
                n_free++;
            end
            r.result_address = addr;
            status_seen[r.status]++;
            due_results.push_back(r);
            return r;
        endfunction

        function void check_res(t_res_word got);
            t_res_word want;
            if (due_results.size() == 0) begin
                $error("unexpected result word: result_address %h status %0d",
                       got.result_address, got.status);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            if (got.result_address !== want.result_address) begin
                $error("result_address: expected %h, got %h",
                       want.result_address, got.result_address);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  start    = 1'b0;
    logic                  busy;
    t_cmd_word             cmd_word = '0;
    logic                  res_valid;
    t_res_word             res_word;
    logic                  cfg_we   = 1'b0;
    logic                  cfg_idx  = CFG_REGION_BASE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    frame_map_scoreboard sb = new();
    logic [31:0]         live_frames [$];
    bit                  idle_on = 1'b1;
    int                  n_settings = 0;
    int unsigned         idle_cycles = 0;

    contiguous_page_frame_allocator_core #(
        .MAX_PAGES  (MAX_PG),
        .PAGE_BYTES (PAGE_B)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (cmd_word),
        .o_res_valid (res_valid),
        .o_res       (res_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && res_valid === 1'b1) sb.check_res(res_word);
    end

    initial begin
        while (idle_cycles < IDLE_LIM) begin
            @(posedge i_clk);
            if ((start && busy === 1'b0) || res_valid === 1'b1) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic rest(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic issue(input logic op, input logic [12:0] pages, input logic [31:0] frame);
        t_cmd_word w;
        t_res_word pred;
        w.opcode        = op;
        w.request_pages = pages;
        w.frame_address = frame;
        start    <= 1'b1;
        cmd_word <= w;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        pred = sb.note_cmd(w);
        if (op == OP_ALLOC && pred.status == RS_OK) live_frames.push_back(pred.result_address);
        if (idle_on && $urandom_range(0, 3) == 0) rest($urandom_range(1, 15));
    endtask

    task automatic settle();
        start <= 1'b0;
        while (sb.due_results.size() != 0 || busy !== 1'b0) @(posedge i_clk);
    endtask

    // both registers written back to back; write enable lowered once
    task automatic set_region(input logic [31:0] base, input logic [12:0] count,
                              input bit junk_hi);
        logic [31:0] cdata;
        cdata = junk_hi ? $urandom() : 32'd0;
        cdata[PAGE_COUNT_W-1:0] = count;
        settle();
        if (base != sb.region_base) live_frames.delete();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_REGION_BASE;
        cfg_data <= base;
        @(posedge i_clk);
        sb.set_cfg(CFG_REGION_BASE, base);
        cfg_idx  <= CFG_PAGE_COUNT;
        cfg_data <= cdata;
        @(posedge i_clk);
        sb.set_cfg(CFG_PAGE_COUNT, cdata);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [31:0] aligned_base();
        return $urandom() & ~(PAGE_B - 1);
    endfunction

    task automatic random_item();
        int unsigned n;
        int unsigned hi;
        int unsigned sel;
        int unsigned pick;
        logic [31:0] frame;
        n  = sb.live_pages();
        hi = (n == 0) ? 1 : ((n < 8) ? n : 8);
        if ($urandom_range(0, 99) < 55) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                issue(OP_ALLOC, 13'($urandom_range(1, hi)), $urandom());
            end else if (sel < 9) begin
                issue(OP_ALLOC, 13'($urandom_range(0, n + 2)), $urandom());
            end else begin
                issue(OP_ALLOC, 13'($urandom_range(0, 8191)), $urandom());
            end
        end else begin
            if (live_frames.size() != 0 && $urandom_range(0, 99) < 65) begin
                pick  = $urandom_range(0, live_frames.size() - 1);
                frame = live_frames[pick];
                live_frames.delete(pick);
            end else begin
                case ($urandom_range(0, 3))
                    0: frame = sb.region_base + $urandom_range(0, hi * 4) * PAGE_B;
                    1: frame = $urandom();
                    2: frame = sb.region_base + $urandom_range(0, hi) * PAGE_B
                               + $urandom_range(1, PAGE_B - 1);
                    default: frame = $urandom_range(0, 1) ? sb.region_base - PAGE_B
                                                         : sb.region_base + n * PAGE_B;
                endcase
            end
            issue(OP_FREE, 13'($urandom_range(0, 8191)), frame);
        end
    endtask

    initial begin
        logic [31:0] b;
        b = REGION_BASE_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // map clear after reset
        while (busy !== 1'b0) @(posedge i_clk);

        // reset settings: full region
        issue(OP_ALLOC, 13'd1, 32'd0);
        issue(OP_ALLOC, 13'd0, 32'hFFFF_FFFF);
        issue(OP_ALLOC, 13'd4097, 32'd0);
        issue(OP_ALLOC, 13'h1FFF, 32'd0);
        issue(OP_ALLOC, 13'd3, 32'd0);
        issue(OP_FREE, 13'd0, b + 2 * PAGE_B);
        issue(OP_FREE, 13'd0, b + 3 * PAGE_B);
        issue(OP_FREE, 13'h1FFF, b + PAGE_B);
        issue(OP_FREE, 13'd0, b);
        issue(OP_FREE, 13'd0, b);
        issue(OP_FREE, 13'd0, b - PAGE_B);
        issue(OP_FREE, 13'd0, b + MAX_PG * PAGE_B);
        issue(OP_FREE, 13'd0, b + 1);
        issue(OP_ALLOC, 13'd4096, 32'd0);
        issue(OP_ALLOC, 13'd1, 32'd0);
        issue(OP_FREE, 13'd0, b);

        // page count above the map size acts as the map size
        set_region(b, 13'h1FFF, 1'b0);
        issue(OP_FREE, 13'd0, b + (MAX_PG - 1) * PAGE_B);
        issue(OP_FREE, 13'd0, b + MAX_PG * PAGE_B);

        // shrink under a block: broken chain, then orphaned part
        set_region(b, 13'd16, 1'b0);
        issue(OP_ALLOC, 13'd10, 32'd0);
        set_region(b, 13'd5, 1'b0);
        issue(OP_FREE, 13'd0, b);
        issue(OP_ALLOC, 13'd6, 32'd0);
        issue(OP_ALLOC, 13'd5, 32'd0);
        set_region(b, 13'd16, 1'b0);
        issue(OP_FREE, 13'd0, b + 5 * PAGE_B);
        issue(OP_FREE, 13'd0, b);

        set_region(32'd0, 13'd0, 1'b0);
        issue(OP_ALLOC, 13'd1, 32'd0);
        issue(OP_FREE, 13'd0, 32'd0);

        // base near the top: addresses wrap
        set_region(32'hFFFF_F000, 13'd4, 1'b0);
        issue(OP_ALLOC, 13'd2, 32'd0);
        issue(OP_ALLOC, 13'd1, 32'd0);
        issue(OP_FREE, 13'd0, 32'h0000_1000);
        issue(OP_FREE, 13'd0, 32'hFFFF_F000);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_region(aligned_base(), 13'($urandom_range(8, 40)), 1'b1);
                1: set_region(sb.region_base, 13'(sb.page_count / 2), 1'b1);
                2: set_region($urandom(), 13'($urandom_range(1, 24)), 1'b1);
                3: set_region(aligned_base(), 13'd1, 1'b0);
                4: set_region(aligned_base(), 13'd4096, 1'b1);
                default: set_region(32'hFFFF_0000, 13'd32, 1'b0);
            endcase
            idle_on = (ph < 5);
            for (int k = 0; k < 18; k++) begin
                if (k == 9 && (ph == 0 || $urandom_range(0, 1) == 1)) settle();
                random_item();
            end
        end

        settle();
        repeat (50) @(posedge i_clk);
        if (sb.due_results.size() != 0) begin
            $error("%0d result words never arrived", sb.due_results.size());
            sb.mismatches++;
        end
        $display("Covered %0d commands (%0d allocate, %0d free) over %0d region settings",
                 sb.n_alloc + sb.n_free, sb.n_alloc, sb.n_free, n_settings);
        $display("Status mix: ok %0d, no room %0d, bad count %0d, out of bound %0d, misaligned %0d, double free %0d, not head %0d, broken chain %0d",
                 sb.status_seen[RS_OK], sb.status_seen[RS_NO_ROOM],
                 sb.status_seen[RS_BAD_COUNT], sb.status_seen[RS_OUT_OF_BOUND],
                 sb.status_seen[RS_MISALIGNED], sb.status_seen[RS_DOUBLE_FREE],
                 sb.status_seen[RS_NOT_HEAD], sb.status_seen[RS_BROKEN]);
        if (sb.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
